/* design/d2e_pkg.sv */
package d2e_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int OffW   = 23;
  localparam int WdW    = 3;
  localparam int LenW   = 5;

  // running offset: covers -719529 up to about 5.3e6 for any 14-bit year
  localparam int AccW = 24;

  // quotient by 100 through a reciprocal, exact for operands below 2^15
  localparam int OpW        = 15;
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam int QW         = 8;
  localparam int ProdW      = OpW + RecipW;
  localparam logic [RecipW-1:0] Recip100 = RecipW'(5243);

  // days from 1 January of year 0 to 1 January 1970
  localparam int EpochDays = 719528;
  localparam int OffsetMax = 4194303;
  // multiple of 7 that lifts every offset above zero, plus 4 for a thursday epoch
  localparam int WdBias    = 719541;

  typedef enum logic [1:0] {
    DIV_CEIL100  = 2'd0,
    DIV_CEIL400  = 2'd1,
    DIV_FLOOR100 = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_en;
    div_sel_t div_sel;
    logic     base;
    logic     mon_add;
    logic     finish;
  } d2e_cmd_t;

  typedef struct packed {
    logic mon_more;
    logic out_busy;
  } d2e_stat_t;

  function automatic logic [LenW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
    logic [LenW-1:0] len;
    case (m) inside
      4, 6, 9, 11:           len = LenW'(30);
      1, 3, 5, 7, 8, 10, 12: len = LenW'(31);
      2:                     len = leap ? LenW'(29) : LenW'(28);
      default:               len = LenW'(28);
    endcase
    return len;
  endfunction

  // 8 == 1 mod 7, so octal digits sum to the same residue
  function automatic logic [WdW-1:0] mod7(input logic [AccW-1:0] u);
    logic [5:0] s;
    logic [3:0] s2;
    logic [3:0] r;
    s = '0;
    for (int i = 0; i < AccW / 3; i++) begin
      s = s + 6'(u[3*i +: 3]);
    end
    s2 = 4'(s[5:3]) + 4'(s[2:0]);
    if (s2 >= 4'd14) begin
      r = s2 - 4'd14;
    end else if (s2 >= 4'd7) begin
      r = s2 - 4'd7;
    end else begin
      r = s2;
    end
    return r[WdW-1:0];
  endfunction

endpackage

/* design/d2e_if.sv */
interface d2e_date_if;
  logic                       valid;
  logic                       ready;
  logic [d2e_pkg::DayW-1:0]   cal_day;
  logic [d2e_pkg::MonthW-1:0] cal_month;
  logic [d2e_pkg::YearW-1:0]  cal_year;

  modport source(output valid, cal_day, cal_month, cal_year, input ready);
  modport sink(input valid, cal_day, cal_month, cal_year, output ready);
endinterface

interface d2e_epoch_if;
  logic                            valid;
  logic                            ready;
  logic signed [d2e_pkg::OffW-1:0] day_offset;
  logic [d2e_pkg::WdW-1:0]         weekday;
  logic                            leap_flag;
  logic [d2e_pkg::LenW-1:0]        month_length;

  modport source(output valid, day_offset, weekday, leap_flag, month_length, input ready);
  modport sink(input valid, day_offset, weekday, leap_flag, month_length, output ready);
endinterface

/* design/d2e_ctrl.sv */
module d2e_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  d2e_pkg::d2e_stat_t stat,
  output d2e_pkg::d2e_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV0 = 7'b0000010,
    S_DIV1 = 7'b0000100,
    S_DIV2 = 7'b0001000,
    S_BASE = 7'b0010000,
    S_MON  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.div_sel = d2e_pkg::DIV_CEIL100;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV0;
        end
      end
      S_DIV0: begin
        cmd.div_en  = 1'b1;
        cmd.div_sel = d2e_pkg::DIV_CEIL100;
        state_next  = S_DIV1;
      end
      S_DIV1: begin
        cmd.div_en  = 1'b1;
        cmd.div_sel = d2e_pkg::DIV_CEIL400;
        state_next  = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_en  = 1'b1;
        cmd.div_sel = d2e_pkg::DIV_FLOOR100;
        state_next  = S_BASE;
      end
      S_BASE: begin
        cmd.base   = 1'b1;
        state_next = S_MON;
      end
      S_MON: begin
        // one earlier month added per cycle
        if (stat.mon_more) begin
          cmd.mon_add = 1'b1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* design/d2e_dp.sv */
module d2e_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  d2e_pkg::d2e_cmd_t          cmd,
  output d2e_pkg::d2e_stat_t         stat,
  input  logic [d2e_pkg::DayW-1:0]   cal_day,
  input  logic [d2e_pkg::MonthW-1:0] cal_month,
  input  logic [d2e_pkg::YearW-1:0]  cal_year,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [d2e_pkg::OffW-1:0]   day_offset,
  output logic [d2e_pkg::WdW-1:0]    weekday,
  output logic                       leap_flag,
  output logic [d2e_pkg::LenW-1:0]   month_length
);

  localparam int AccW = d2e_pkg::AccW;
  localparam int OpW  = d2e_pkg::OpW;
  localparam int QW   = d2e_pkg::QW;

  logic [d2e_pkg::DayW-1:0]   d;
  logic [d2e_pkg::MonthW-1:0] m;
  logic [d2e_pkg::YearW-1:0]  y;
  logic [d2e_pkg::MonthW-1:0] mi;
  logic [QW-1:0]              q100c;
  logic [QW-1:0]              q400c;
  logic [QW-1:0]              q100f;
  logic [AccW-1:0]            off;
  logic                       leap;
  logic [d2e_pkg::LenW-1:0]   mlen;

  logic [OpW-1:0]            div_op;
  logic [d2e_pkg::ProdW-1:0] prod;
  logic [QW-1:0]             quo;

  logic [AccW-1:0]           base_val;
  logic                      leap_val;
  logic [OpW-1:0]            hund;
  logic [AccW-1:0]           wd_arg;
  logic                      sat;

  // shared reciprocal multiplier, one quotient per cycle
  always_comb begin
    case (cmd.div_sel)
      d2e_pkg::DIV_CEIL100:  div_op = OpW'(y) + OpW'(99);
      d2e_pkg::DIV_CEIL400:  div_op = (OpW'(y) + OpW'(399)) >> 2;
      d2e_pkg::DIV_FLOOR100: div_op = OpW'(y);
      default:               div_op = OpW'(y);
    endcase
  end

  assign prod = d2e_pkg::ProdW'(div_op) * d2e_pkg::ProdW'(d2e_pkg::Recip100);
  assign quo  = prod[d2e_pkg::RecipShift +: QW];

  // 365*y + ceil(y/4) - ceil(y/100) + ceil(y/400), less the epoch, plus day - 1
  assign base_val = AccW'(y) * AccW'(365)
                  + AccW'((OpW'(y) + OpW'(3)) >> 2)
                  - AccW'(q100c) + AccW'(q400c)
                  - AccW'(d2e_pkg::EpochDays)
                  + AccW'(d) - AccW'(1);

  // centennial years are leap only when the century count is a multiple of 4
  assign hund     = OpW'(q100f) * OpW'(100);
  assign leap_val = (y[1:0] == 2'b00) && ((OpW'(y) != hund) || (q100f[1:0] == 2'b00));

  assign wd_arg = off + AccW'(d2e_pkg::WdBias);
  assign sat    = $signed(off) > $signed(AccW'(d2e_pkg::OffsetMax));

  assign stat.mon_more = (mi < m);
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d  <= cal_day;
      m  <= cal_month;
      y  <= cal_year;
      mi <= d2e_pkg::MonthW'(1);
    end
    if (cmd.div_en) begin
      case (cmd.div_sel)
        d2e_pkg::DIV_CEIL100:  q100c <= quo;
        d2e_pkg::DIV_CEIL400:  q400c <= quo;
        d2e_pkg::DIV_FLOOR100: q100f <= quo;
        default:               q100f <= quo;
      endcase
    end
    if (cmd.base) begin
      off  <= base_val;
      leap <= leap_val;
      mlen <= d2e_pkg::month_len(m, leap_val);
    end
    if (cmd.mon_add) begin
      off <= off + AccW'(d2e_pkg::month_len(mi, leap));
      mi  <= mi + d2e_pkg::MonthW'(1);
    end
    if (cmd.finish) begin
      day_offset   <= sat ? d2e_pkg::OffW'(d2e_pkg::OffsetMax) : off[d2e_pkg::OffW-1:0];
      weekday      <= d2e_pkg::mod7(wd_arg);
      leap_flag    <= leap;
      month_length <= mlen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* design/date_to_epoch_day_and_weekday.sv */
// sequence: after an input transaction, quotients ceil(y/100), ceil(y/400) and floor(y/100)
// on the shared multiplier, a base step, one step per earlier month plus a closing step, and
// a finish step that waits while the previous result is stalled; result valid is registered
// a new date is taken only in idle, after the last one is finished; the month loop sets the pace
// reset: synchronous active-high rst returns the sequencer to idle and drops result valid
module date_to_epoch_day_and_weekday (
  input logic          clk,
  input logic          rst,
  d2e_date_if.sink     date,
  d2e_epoch_if.source  epoch
);

  d2e_pkg::d2e_cmd_t  cmd;
  d2e_pkg::d2e_stat_t stat;
  logic [d2e_pkg::OffW-1:0] offset_bits;

  d2e_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (date.valid),
    .in_ready (date.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  d2e_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cal_day      (date.cal_day),
    .cal_month    (date.cal_month),
    .cal_year     (date.cal_year),
    .out_valid    (epoch.valid),
    .out_ready    (epoch.ready),
    .day_offset   (offset_bits),
    .weekday      (epoch.weekday),
    .leap_flag    (epoch.leap_flag),
    .month_length (epoch.month_length)
  );

  assign epoch.day_offset = $signed(offset_bits);

endmodule

/* design/d2e_checker.sv */
module d2e_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [d2e_pkg::OffW-1:0] day_offset,
  input logic [d2e_pkg::WdW-1:0]       weekday,
  input logic                          leap_flag,
  input logic [d2e_pkg::LenW-1:0]      month_length
);

  // one date in flight: no transaction right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(day_offset) && $stable(weekday))
    else $error("stalled result changed or dropped");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month_length == 5'd28 || month_length == 5'd29 ||
                   month_length == 5'd30 || month_length == 5'd31) && weekday != 3'd7)
    else $error("result fields out of range");

  // a 29-day month must come with the leap flag set (february of a leap year)
  a_leap_feb: assert property (@(posedge clk) disable iff (rst)
    out_valid && month_length == 5'd29 |-> leap_flag)
    else $error("29-day month without leap year");

endmodule

bind date_to_epoch_day_and_weekday d2e_checker u_d2e_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (date.valid),
  .in_ready     (date.ready),
  .out_valid    (epoch.valid),
  .out_ready    (epoch.ready),
  .day_offset   (epoch.day_offset),
  .weekday      (epoch.weekday),
  .leap_flag    (epoch.leap_flag),
  .month_length (epoch.month_length)
);
